FILE: hdl/erng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erng_pkg
// Shared constants for the three-channel echo ranger.
// ----------------------------------------------------------------------------
package erng_pkg;

	localparam int unsigned CH          = 3;   // front, back, right
	localparam int unsigned LEVEL_W     = 3;
	localparam int unsigned TS_W        = 16;
	localparam int unsigned DIST_W      = 11;
	localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

	// elapsed / 58 is done as (elapsed >> 1) / 29
	localparam int unsigned DIV_HALF     = 29;
	localparam int unsigned DIV_HALF_LOG = 5;  // 2^4 < 29 <= 2^5

	localparam int unsigned QUEUE_DEPTH = 4;

endpackage : erng_pkg
`default_nettype wire

FILE: hdl/erng_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erng_front
// Edge detection, pulse start capture, elapsed time and reciprocal multiply.
// ----------------------------------------------------------------------------
module erng_front import erng_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [LEVEL_W-1:0]   echo_levels,
	input  wire logic [TS_W-1:0]      timestamp,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CH-1:0]             out_fall,
	output logic [CH*(TIME_WIDTH-5)-1:0] out_quot
);

	localparam int unsigned YW    = TIME_WIDTH - 1;
	localparam int unsigned SHIFT = YW + DIV_HALF_LOG;
	localparam int unsigned PW    = 2 * YW + 1;
	localparam int unsigned QW    = PW - SHIFT;
	localparam logic [63:0] MAGIC =
		((64'd1 << SHIFT) + 64'(DIV_HALF - 1)) / 64'(DIV_HALF);

	logic [LEVEL_W-1:0]    prev_q;
	logic [TIME_WIDTH-1:0] start_q [CH];
	logic [TIME_WIDTH-1:0] now;
	logic [CH-1:0]         rise;
	logic [CH-1:0]         fall;
	logic                  in_fire;

	logic                  s1_v;
	logic [CH-1:0]         fall_s1;
	logic [YW-1:0]         half_s1 [CH];
	logic                  s1_ready;

	logic                  s2_v;
	logic [CH-1:0]         fall_s2;
	logic [QW-1:0]         quot_s2 [CH];
	logic                  s2_ready;

	logic [PW-1:0]         prod [CH];
	logic [TIME_WIDTH-1:0] elapsed [CH];

	assign now      = TIME_WIDTH'(timestamp);
	assign rise     = echo_levels & ~prev_q;
	assign fall     = ~echo_levels & prev_q;
	assign s2_ready = !s2_v || out_ready;
	assign s1_ready = !s1_v || s2_ready;
	assign full     = !s1_ready;
	assign in_fire  = push && s1_ready;

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			elapsed[c] = now - start_q[c];
			prod[c]    = PW'(half_s1[c]) * PW'(MAGIC[YW:0]);
		end
	end

	// level history and pulse starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int c = 0; c < CH; c++) start_q[c] <= '0;
		end else if (in_fire) begin
			prev_q <= echo_levels;
			for (int c = 0; c < CH; c++) begin
				if (rise[c]) start_q[c] <= now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			if (s1_ready) s1_v <= push;
			if (s2_ready) s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			fall_s1 <= fall;
			for (int c = 0; c < CH; c++) half_s1[c] <= elapsed[c][TIME_WIDTH-1:1];
		end
		if (s2_ready && s1_v) begin
			fall_s2 <= fall_s1;
			for (int c = 0; c < CH; c++) quot_s2[c] <= prod[c][PW-1:SHIFT];
		end
	end

	assign out_valid = s2_v;
	assign out_fall  = fall_s2;
	always_comb begin
		for (int c = 0; c < CH; c++) out_quot[c*QW +: QW] = quot_s2[c];
	end

endmodule : erng_front
`default_nettype wire

FILE: hdl/erng_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erng_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module erng_queue import erng_pkg::*; #(
	parameter int unsigned WIDTH = 39
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign in_ready  = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (rd_en) rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (wr_en && !rd_en)      cnt_q <= cnt_q + CNT_W'(1);
			else if (rd_en && !wr_en) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_q] <= in_data;
	end

endmodule : erng_queue
`default_nettype wire

FILE: hdl/erng_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erng_back
// Saturates quotients, keeps the latest distances and holds the result item.
// ----------------------------------------------------------------------------
module erng_back import erng_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [CH-1:0]            in_fall,
	input  wire logic [CH*(TIME_WIDTH-5)-1:0] in_quot,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [DIST_W-1:0]             front_cm,
	output logic [DIST_W-1:0]             back_cm,
	output logic [DIST_W-1:0]             right_cm,
	output logic                          front_updated,
	output logic                          back_updated,
	output logic                          right_updated
);

	localparam int unsigned QW = TIME_WIDTH - 5;

	logic [DIST_W-1:0] dist_q     [CH];
	logic [DIST_W-1:0] dist_next  [CH];
	logic [DIST_W-1:0] out_dist_q [CH];
	logic [CH-1:0]     out_upd_q;
	logic              out_v_q;
	logic [31:0]       q32 [CH];
	logic              take;

	assign in_ready = !out_v_q || pop;
	assign take     = in_valid && in_ready;

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			q32[c] = 32'(in_quot[c*QW +: QW]);
			if (!in_fall[c])
				dist_next[c] = dist_q[c];
			else if (q32[c] > 32'(DIST_MAX))
				dist_next[c] = DIST_MAX;
			else
				dist_next[c] = q32[c][DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			for (int c = 0; c < CH; c++) dist_q[c] <= '0;
		end else begin
			if (in_ready) out_v_q <= in_valid;
			if (take) begin
				for (int c = 0; c < CH; c++) dist_q[c] <= dist_next[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_upd_q <= in_fall;
			for (int c = 0; c < CH; c++) out_dist_q[c] <= dist_next[c];
		end
	end

	assign empty         = !out_v_q;
	assign front_cm      = out_dist_q[0];
	assign back_cm       = out_dist_q[1];
	assign right_cm      = out_dist_q[2];
	assign front_updated = out_upd_q[0];
	assign back_updated  = out_upd_q[1];
	assign right_updated = out_upd_q[2];

endmodule : erng_back
`default_nettype wire

FILE: hdl/three_channel_echo_ranger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_channel_echo_ranger
// Pulse-width ranging on three ultrasonic echo lines.
// ----------------------------------------------------------------------------
// Takes one item per clock while full is low: three echo line levels and a
// microsecond stamp. A rising line records its start time; a falling line
// turns the elapsed time (mod 2^TIME_WIDTH) into centimetres by dividing by
// 58. Every item gives one result with all three latest distances and
// per-channel update flags. Sustained rate is one item per cycle while pop
// keeps the result drained; an item's result reaches the result ports
// through two front stages, the four-entry queue and the output register.
// The division is a reciprocal multiply, one multiplier per channel,
// registered before the back part saturates it.
// ----------------------------------------------------------------------------
module three_channel_echo_ranger import erng_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [LEVEL_W-1:0]  echo_levels,
	input  wire logic [TS_W-1:0]     timestamp,
	output logic                     empty,
	input  wire logic                pop,
	output logic [DIST_W-1:0]        front_cm,
	output logic [DIST_W-1:0]        back_cm,
	output logic [DIST_W-1:0]        right_cm,
	output logic                     front_updated,
	output logic                     back_updated,
	output logic                     right_updated
);

	localparam int unsigned QW = TIME_WIDTH - 5;
	localparam int unsigned DW = CH + CH * QW;

	logic                 fr_valid;
	logic                 fr_ready;
	logic [CH-1:0]        fr_fall;
	logic [CH*QW-1:0]     fr_quot;
	logic                 bk_valid;
	logic                 bk_ready;
	logic [DW-1:0]        bk_data;

	erng_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.echo_levels (echo_levels),
		.timestamp   (timestamp),
		.out_valid   (fr_valid),
		.out_ready   (fr_ready),
		.out_fall    (fr_fall),
		.out_quot    (fr_quot)
	);

	erng_queue #(.WIDTH(DW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   ({fr_fall, fr_quot}),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_data  (bk_data)
	);

	erng_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (bk_valid),
		.in_ready      (bk_ready),
		.in_fall       (bk_data[DW-1 -: CH]),
		.in_quot       (bk_data[CH*QW-1:0]),
		.empty         (empty),
		.pop           (pop),
		.front_cm      (front_cm),
		.back_cm       (back_cm),
		.right_cm      (right_cm),
		.front_updated (front_updated),
		.back_updated  (back_updated),
		.right_updated (right_updated)
	);

`ifndef ASSERT_OFF
	// a stalled front item must not vanish before the queue takes it
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !fr_ready |=> fr_valid)
		else $error("front item lost while queue full");

	// queued item stays until the back part takes it
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bk_valid && !bk_ready |=> bk_valid)
		else $error("queued item lost while output held");

	// full only when both front stages hold items
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> fr_valid && !fr_ready)
		else $error("full without a stalled front");
`endif

endmodule : three_channel_echo_ranger
`default_nettype wire
